[hw/rtl/rvex_pkg.sv]
// rvex_pkg: operation codes, operation classes and the queue word type
// shared by the execute unit front, back and divider. no dependencies.
package rvex_pkg;

	localparam logic [5:0] F_ADD    = 6'd0;
	localparam logic [5:0] F_SLT    = 6'd1;
	localparam logic [5:0] F_SLTU   = 6'd2;
	localparam logic [5:0] F_AND    = 6'd3;
	localparam logic [5:0] F_OR     = 6'd4;
	localparam logic [5:0] F_XOR    = 6'd5;
	localparam logic [5:0] F_SLL    = 6'd6;
	localparam logic [5:0] F_SRL    = 6'd7;
	localparam logic [5:0] F_SUB    = 6'd8;
	localparam logic [5:0] F_SRA    = 6'd9;
	localparam logic [5:0] F_ADDI   = 6'd10;
	localparam logic [5:0] F_SLTI   = 6'd11;
	localparam logic [5:0] F_SLTIU  = 6'd12;
	localparam logic [5:0] F_ANDI   = 6'd13;
	localparam logic [5:0] F_ORI    = 6'd14;
	localparam logic [5:0] F_XORI   = 6'd15;
	localparam logic [5:0] F_SLLI   = 6'd16;
	localparam logic [5:0] F_SRLI   = 6'd17;
	localparam logic [5:0] F_SRAI   = 6'd18;
	localparam logic [5:0] F_LUI    = 6'd19;
	localparam logic [5:0] F_AUIPC  = 6'd20;
	localparam logic [5:0] F_MUL    = 6'd21;
	localparam logic [5:0] F_MULH   = 6'd22;
	localparam logic [5:0] F_MULHSU = 6'd23;
	localparam logic [5:0] F_MULHU  = 6'd24;
	localparam logic [5:0] F_DIV    = 6'd25;
	localparam logic [5:0] F_DIVU   = 6'd26;
	localparam logic [5:0] F_REM    = 6'd27;
	localparam logic [5:0] F_REMU   = 6'd28;
	localparam logic [5:0] F_LB     = 6'd29;
	localparam logic [5:0] F_LH     = 6'd30;
	localparam logic [5:0] F_LW     = 6'd31;
	localparam logic [5:0] F_LBU    = 6'd32;
	localparam logic [5:0] F_LHU    = 6'd33;
	localparam logic [5:0] F_SB     = 6'd34;
	localparam logic [5:0] F_SH     = 6'd35;
	localparam logic [5:0] F_SW     = 6'd36;
	localparam logic [5:0] F_JAL    = 6'd37;
	localparam logic [5:0] F_JALR   = 6'd38;
	localparam logic [5:0] F_BEQ    = 6'd39;
	localparam logic [5:0] F_BNE    = 6'd40;
	localparam logic [5:0] F_BLT    = 6'd41;
	localparam logic [5:0] F_BGE    = 6'd42;
	localparam logic [5:0] F_BLTU   = 6'd43;
	localparam logic [5:0] F_BGEU   = 6'd44;

	localparam logic signed [2:0] ACC_NONE = 3'sd0;
	localparam logic signed [2:0] ACC_SB   = -3'sd1;
	localparam logic signed [2:0] ACC_SH   = -3'sd2;
	localparam logic signed [2:0] ACC_SW   = -3'sd4;
	localparam logic signed [2:0] ACC_UB   = 3'sd1;
	localparam logic signed [2:0] ACC_UH   = 3'sd2;

	localparam int DIV_STAGES = 32;

	typedef enum logic [2:0] {
		CLS_ALU,
		CLS_MUL,
		CLS_DIV,
		CLS_MEM,
		CLS_JUMP,
		CLS_BRANCH,
		CLS_NONE
	} cls_t;

	typedef struct packed {
		logic [5:0]  func;
		cls_t        cls;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] imm;
		logic [31:0] pc;
		logic        pred;
		logic        fin;
	} item_t;

endpackage

[hw/rtl/rvex_front.sv]
// rvex_front: accepts input words, classifies the operation and holds them
// in a two-entry queue for the back part. depends on rvex_pkg.
module rvex_front import rvex_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  func,
	input  logic [31:0] src_a,
	input  logic [31:0] src_b,
	input  logic [31:0] immediate,
	input  logic [31:0] inst_addr,
	input  logic        predicted_taken,
	input  logic        end_mark,
	output logic        q_valid,
	input  logic        q_ready,
	output item_t       q_item
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cls_t       cls;
	item_t      wr_item;
	logic       push;
	logic       pop;

	always_comb begin
		unique case (func) inside
			[F_ADD:F_AUIPC]: cls = CLS_ALU;
			[F_MUL:F_MULHU]: cls = CLS_MUL;
			[F_DIV:F_REMU]:  cls = CLS_DIV;
			[F_LB:F_SW]:     cls = CLS_MEM;
			F_JAL, F_JALR:   cls = CLS_JUMP;
			[F_BEQ:F_BGEU]:  cls = CLS_BRANCH;
			default:         cls = CLS_NONE;
		endcase
	end

	always_comb begin
		wr_item.func = func;
		wr_item.cls  = cls;
		wr_item.a    = src_a;
		wr_item.b    = src_b;
		wr_item.imm  = immediate;
		wr_item.pc   = inst_addr;
		wr_item.pred = predicted_taken;
		wr_item.fin  = end_mark;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

[hw/rtl/rvex_divider.sv]
// rvex_divider: pipelined unsigned restoring divider, one quotient bit per
// stage, advancing on en. depends on rvex_pkg.
module rvex_divider import rvex_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quotient,
	output logic [31:0] remainder
);

	logic [31:0] rem_s [1:DIV_STAGES];
	logic [31:0] quo_s [1:DIV_STAGES];
	logic [31:0] dvs_s [1:DIV_STAGES];

	for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_stage
		logic [31:0] rem_in;
		logic [31:0] quo_in;
		logic [31:0] dvs_in;
		logic [32:0] trial;
		logic [32:0] diff;

		if (i == 1) begin : g_first
			assign rem_in = '0;
			assign quo_in = dividend;
			assign dvs_in = divisor;
		end else begin : g_rest
			assign rem_in = rem_s[i-1];
			assign quo_in = quo_s[i-1];
			assign dvs_in = dvs_s[i-1];
		end

		assign trial = {rem_in, quo_in[31]};
		assign diff  = trial - {1'b0, dvs_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= diff[32] ? trial[31:0] : diff[31:0];
				quo_s[i] <= {quo_in[30:0], ~diff[32]};
				dvs_s[i] <= dvs_in;
			end
		end
	end

	assign quotient  = quo_s[DIV_STAGES];
	assign remainder = rem_s[DIV_STAGES];

endmodule

[hw/rtl/rvex_back.sv]
// rvex_back: executes queued words: alu, branch and address logic, the
// multiplier, the divider pipeline and the output register. depends on
// rvex_pkg and rvex_divider.
module rvex_back import rvex_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  item_t              q_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        result_value,
	output logic [31:0]        mem_address,
	output logic signed [2:0]  access_code,
	output logic [31:0]        next_pc,
	output logic               branch_taken,
	output logic               mispredicted,
	output logic               finished
);

	typedef struct packed {
		logic [31:0]       val;
		logic [31:0]       addr;
		logic signed [2:0] code;
		logic [31:0]       npc;
		logic              taken;
		logic              mis;
		logic              fin;
		logic [31:0]       a;
		logic              isdiv;
		logic              isrem;
		logic              negq;
		logic              negr;
		logic              zero;
	} side_t;

	logic advance;

	logic [31:0]       val_c, addr_c, npc_c;
	logic signed [2:0] code_c;
	logic              taken_c, mis_c, cond;
	logic [31:0]       a, b, imm, pc, pc4;
	logic [32:0]       ma, mb;
	logic [63:0]       prod_c;
	logic              sa, sb;

	logic              v_s1;
	side_t             pre_s1;
	logic              hi_s1;
	logic              ismul_s1;
	logic [63:0]       prod_s1;
	logic [31:0]       dvd_s1, dvs_s1;

	side_t             side0;
	side_t             side_s [DIV_STAGES];
	logic              v_s    [DIV_STAGES];
	logic [31:0]       quo, rem;
	side_t             last;
	logic [31:0]       fval;
	logic              out_v_q;

	assign advance = !out_v_q || out_ready;
	assign q_ready = advance;

	assign a   = q_item.a;
	assign b   = q_item.b;
	assign imm = q_item.imm;
	assign pc  = q_item.pc;
	assign pc4 = pc + 32'd4;

	always_comb begin
		val_c   = '0;
		addr_c  = '0;
		code_c  = ACC_NONE;
		npc_c   = pc4;
		taken_c = 1'b0;
		mis_c   = 1'b0;
		cond    = 1'b0;
		case (q_item.func)
			F_ADD:   val_c = a + b;
			F_SLT:   val_c = {31'd0, $signed(a) < $signed(b)};
			F_SLTU:  val_c = {31'd0, a < b};
			F_AND:   val_c = a & b;
			F_OR:    val_c = a | b;
			F_XOR:   val_c = a ^ b;
			F_SLL:   val_c = a << b[4:0];
			F_SRL:   val_c = a >> b[4:0];
			F_SUB:   val_c = a - b;
			F_SRA:   val_c = $unsigned($signed(a) >>> b[4:0]);
			F_ADDI:  val_c = a + imm;
			F_SLTI:  val_c = {31'd0, $signed(a) < $signed(imm)};
			F_SLTIU: val_c = {31'd0, a < imm};
			F_ANDI:  val_c = a & imm;
			F_ORI:   val_c = a | imm;
			F_XORI:  val_c = a ^ imm;
			F_SLLI:  val_c = a << imm[4:0];
			F_SRLI:  val_c = a >> imm[4:0];
			F_SRAI:  val_c = $unsigned($signed(a) >>> imm[4:0]);
			F_LUI:   val_c = imm;
			F_AUIPC: val_c = pc + imm;
			F_LB, F_SB: code_c = ACC_SB;
			F_LH, F_SH: code_c = ACC_SH;
			F_LW, F_SW: code_c = ACC_SW;
			F_LBU:   code_c = ACC_UB;
			F_LHU:   code_c = ACC_UH;
			F_JAL: begin
				npc_c   = pc + imm;
				val_c   = pc4;
				taken_c = 1'b1;
				mis_c   = !q_item.pred;
			end
			F_JALR: begin
				npc_c   = (a + imm) & 32'hffff_fffe;
				val_c   = pc4;
				taken_c = 1'b1;
				mis_c   = 1'b1;
			end
			F_BEQ:  cond = (a == b);
			F_BNE:  cond = (a != b);
			F_BLT:  cond = $signed(a) < $signed(b);
			F_BGE:  cond = !($signed(a) < $signed(b));
			F_BLTU: cond = a < b;
			F_BGEU: cond = a >= b;
			default: ;
		endcase
		if (q_item.cls == CLS_MEM) begin
			val_c  = b;
			addr_c = a + imm;
		end
		if (q_item.cls == CLS_BRANCH) begin
			taken_c = cond;
			npc_c   = cond ? pc + imm : pc4;
			mis_c   = (cond != q_item.pred);
		end
	end

	// operand sign extension for the high products
	always_comb begin
		sa = 1'b0;
		sb = 1'b0;
		case (q_item.func)
			F_MULH: begin
				sa = a[31];
				sb = b[31];
			end
			F_MULHSU: sa = a[31];
			default: ;
		endcase
		ma     = {sa, a};
		mb     = {sb, b};
		prod_c = 64'($signed(ma) * $signed(mb));
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pre_s1.val   <= val_c;
			pre_s1.addr  <= addr_c;
			pre_s1.code  <= code_c;
			pre_s1.npc   <= npc_c;
			pre_s1.taken <= taken_c;
			pre_s1.mis   <= mis_c;
			pre_s1.fin   <= q_item.fin;
			pre_s1.a     <= a;
			pre_s1.isdiv <= (q_item.cls == CLS_DIV);
			pre_s1.isrem <= (q_item.func == F_REM) || (q_item.func == F_REMU);
			pre_s1.negq  <= (q_item.func == F_DIV) && (a[31] ^ b[31]);
			pre_s1.negr  <= (q_item.func == F_REM) && a[31];
			pre_s1.zero  <= (b == 32'd0);
			hi_s1        <= (q_item.func != F_MUL);
			ismul_s1     <= (q_item.cls == CLS_MUL);
			prod_s1      <= prod_c;
			if ((q_item.func == F_DIV) || (q_item.func == F_REM)) begin
				dvd_s1 <= a[31] ? 32'd0 - a : a;
				dvs_s1 <= b[31] ? 32'd0 - b : b;
			end else begin
				dvd_s1 <= a;
				dvs_s1 <= b;
			end
		end
	end

	always_comb begin
		side0 = pre_s1;
		if (ismul_s1) begin
			side0.val = hi_s1 ? prod_s1[63:32] : prod_s1[31:0];
		end
	end

	rvex_divider u_div (
		.clk       (clk),
		.en        (advance),
		.dividend  (dvd_s1),
		.divisor   (dvs_s1),
		.quotient  (quo),
		.remainder (rem)
	);

	always_ff @(posedge clk) begin
		if (advance) begin
			side_s[0] <= side0;
			for (int i = 1; i < DIV_STAGES; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i < DIV_STAGES; i++) begin
				v_s[i] <= 1'b0;
			end
			out_v_q <= 1'b0;
		end else if (advance) begin
			v_s1   <= q_valid;
			v_s[0] <= v_s1;
			for (int i = 1; i < DIV_STAGES; i++) begin
				v_s[i] <= v_s[i-1];
			end
			out_v_q <= v_s[DIV_STAGES-1];
		end
	end

	assign last = side_s[DIV_STAGES-1];

	always_comb begin
		fval = last.val;
		if (last.isdiv) begin
			if (last.zero) fval = last.isrem ? last.a : 32'hffff_ffff;
			else if (last.isrem) fval = last.negr ? 32'd0 - rem : rem;
			else fval = last.negq ? 32'd0 - quo : quo;
		end
		if (last.fin) fval = last.a;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_value <= fval;
			mem_address  <= last.addr;
			access_code  <= last.code;
			next_pc      <= last.npc;
			branch_taken <= last.taken;
			mispredicted <= last.mis;
			finished     <= last.fin;
		end
	end

	assign out_valid = out_v_q;

endmodule

[hw/rtl/rv32im_execute_unit.sv]
// rv32im_execute_unit: top level of the execute unit, front queue and back
// pipeline. depends on rvex_pkg, rvex_front and rvex_back.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   func src_a src_b immediate inst_addr
//                                              predicted_taken end_mark
//   out      output     out_valid / out_ready result_value mem_address access_code
//                                              next_pc branch_taken mispredicted finished
//
// one word per cycle sustained while out is not stalled; every word passes through
// the 32-stage divider pipeline
// reset clears the queue and all stage valid bits; payload is not reset
// a stall on out freezes the whole back pipeline; the two-entry queue then
// fills and drops in_ready
module rv32im_execute_unit import rvex_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [5:0]        func,
	input  logic [31:0]       src_a,
	input  logic [31:0]       src_b,
	input  logic [31:0]       immediate,
	input  logic [31:0]       inst_addr,
	input  logic              predicted_taken,
	input  logic              end_mark,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       result_value,
	output logic [31:0]       mem_address,
	output logic signed [2:0] access_code,
	output logic [31:0]       next_pc,
	output logic              branch_taken,
	output logic              mispredicted,
	output logic              finished
);

	logic  q_valid;
	logic  q_ready;
	item_t q_item;

	rvex_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.src_a           (src_a),
		.src_b           (src_b),
		.immediate       (immediate),
		.inst_addr       (inst_addr),
		.predicted_taken (predicted_taken),
		.end_mark        (end_mark),
		.q_valid         (q_valid),
		.q_ready         (q_ready),
		.q_item          (q_item)
	);

	rvex_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_item       (q_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.mem_address  (mem_address),
		.access_code  (access_code),
		.next_pc      (next_pc),
		.branch_taken (branch_taken),
		.mispredicted (mispredicted),
		.finished     (finished)
	);

endmodule

[dv/tb_rv32im_execute_unit.sv]
// tb_rv32im_execute_unit: self-checking testbench for the rv32im execute unit.
// a directed table and random words are checked against a local predictor.
// depends on rvex_pkg and rv32im_execute_unit.
`timescale 1ns / 1ps

module tb_rv32im_execute_unit;
	import rvex_pkg::*;

	typedef struct packed {
		logic [5:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] imm;
		logic [31:0] pc;
		logic        pred;
		logic        fin;
	} instr_t;

	typedef struct packed {
		logic [31:0]       val;
		logic [31:0]       addr;
		logic signed [2:0] acc;
		logic [31:0]       npc;
		logic              taken;
		logic              mis;
		logic              fin;
	} exec_t;

	typedef struct packed {
		instr_t i;
		logic   has_res;
		exec_t  r;
	} row_t;

	localparam int WATCHDOG = 5000;
	localparam int N_RANDOM = 1330;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [5:0] func = '0;
	logic [31:0] src_a = '0, src_b = '0, immediate = '0, inst_addr = '0;
	logic predicted_taken = 1'b0, end_mark = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] result_value, mem_address, next_pc;
	logic signed [2:0] access_code;
	logic branch_taken, mispredicted, finished;

	exec_t expected_q[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_recv = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	rv32im_execute_unit dut (.*);

	function automatic logic signed_lt(logic [31:0] x, logic [31:0] y);
		return $signed(x) < $signed(y);
	endfunction

	function automatic exec_t execute(instr_t i);
		exec_t r;
		logic [63:0] p;
		logic [31:0] q;
		logic cond;
		logic is_br;
		r = '0;
		r.npc = i.pc + 32'd4;
		is_br = 1'b0;
		cond = 1'b0;
		case (i.op)
			F_ADD: r.val = i.a + i.b;
			F_SLT: r.val = {31'd0, signed_lt(i.a, i.b)};
			F_SLTU: r.val = {31'd0, i.a < i.b};
			F_AND: r.val = i.a & i.b;
			F_OR: r.val = i.a | i.b;
			F_XOR: r.val = i.a ^ i.b;
			F_SLL: r.val = i.a << i.b[4:0];
			F_SRL: r.val = i.a >> i.b[4:0];
			F_SUB: r.val = i.a - i.b;
			F_SRA: r.val = $unsigned($signed(i.a) >>> i.b[4:0]);
			F_ADDI: r.val = i.a + i.imm;
			F_SLTI: r.val = {31'd0, signed_lt(i.a, i.imm)};
			F_SLTIU: r.val = {31'd0, i.a < i.imm};
			F_ANDI: r.val = i.a & i.imm;
			F_ORI: r.val = i.a | i.imm;
			F_XORI: r.val = i.a ^ i.imm;
			F_SLLI: r.val = i.a << i.imm[4:0];
			F_SRLI: r.val = i.a >> i.imm[4:0];
			F_SRAI: r.val = $unsigned($signed(i.a) >>> i.imm[4:0]);
			F_LUI: r.val = i.imm;
			F_AUIPC: r.val = i.pc + i.imm;
			F_MUL: r.val = i.a * i.b;
			F_MULH: begin
				p = $unsigned($signed({{32{i.a[31]}}, i.a}) * $signed({{32{i.b[31]}}, i.b}));
				r.val = p[63:32];
			end
			F_MULHSU: begin
				p = $unsigned($signed({{32{i.a[31]}}, i.a}) * $signed({32'd0, i.b}));
				r.val = p[63:32];
			end
			F_MULHU: begin
				p = {32'd0, i.a} * {32'd0, i.b};
				r.val = p[63:32];
			end
			F_DIV: begin
				if (i.b == 0) begin
					r.val = '1;
				end else begin
					q = (i.a[31] ? -i.a : i.a) / (i.b[31] ? -i.b : i.b);
					r.val = (i.a[31] ^ i.b[31]) ? -q : q;
				end
			end
			F_DIVU: r.val = (i.b == 0) ? '1 : i.a / i.b;
			F_REM: begin
				if (i.b == 0) begin
					r.val = i.a;
				end else begin
					q = (i.a[31] ? -i.a : i.a) % (i.b[31] ? -i.b : i.b);
					r.val = i.a[31] ? -q : q;
				end
			end
			F_REMU: r.val = (i.b == 0) ? i.a : i.a % i.b;
			F_LB, F_LH, F_LW, F_LBU, F_LHU, F_SB, F_SH, F_SW: begin
				r.val = i.b;
				r.addr = i.a + i.imm;
				case (i.op)
					F_LB, F_SB: r.acc = ACC_SB;
					F_LH, F_SH: r.acc = ACC_SH;
					F_LW, F_SW: r.acc = ACC_SW;
					F_LBU: r.acc = ACC_UB;
					default: r.acc = ACC_UH;
				endcase
			end
			F_JAL: begin
				r.npc = i.pc + i.imm;
				r.val = i.pc + 32'd4;
				r.taken = 1'b1;
				r.mis = !i.pred;
			end
			F_JALR: begin
				r.npc = (i.a + i.imm) & ~32'd1;
				r.val = i.pc + 32'd4;
				r.taken = 1'b1;
				r.mis = 1'b1;
			end
			F_BEQ: begin is_br = 1'b1; cond = i.a == i.b; end
			F_BNE: begin is_br = 1'b1; cond = i.a != i.b; end
			F_BLT: begin is_br = 1'b1; cond = signed_lt(i.a, i.b); end
			F_BGE: begin is_br = 1'b1; cond = !signed_lt(i.a, i.b); end
			F_BLTU: begin is_br = 1'b1; cond = i.a < i.b; end
			F_BGEU: begin is_br = 1'b1; cond = i.a >= i.b; end
			default: ;
		endcase
		if (is_br) begin
			r.taken = cond;
			r.npc = cond ? i.pc + i.imm : i.pc + 32'd4;
			r.mis = cond != i.pred;
		end
		if (i.fin)
			r.val = i.a;
		r.fin = i.fin;
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hffffffff;
			2: return 32'h80000000;
			3: return $urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(instr_t i);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= i.op;
		src_a <= i.a;
		src_b <= i.b;
		immediate <= i.imm;
		inst_addr <= i.pc;
		predicted_taken <= i.pred;
		end_mark <= i.fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_q.push_back(execute(i));
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
	endtask

	// receiver
	always @(negedge clk) begin
		if (hold_recv)
			out_ready <= 1'b0;
		else
			out_ready <= $urandom_range(0, 99) >= recv_idle;
	end

	// result check and watchdog
	always @(posedge clk) begin
		exec_t e;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (result_value !== e.val) begin
					$error("result_value exp %h got %h", e.val, result_value); errors++;
				end
				if (mem_address !== e.addr) begin
					$error("mem_address exp %h got %h", e.addr, mem_address); errors++;
				end
				if (access_code !== e.acc) begin
					$error("access_code exp %0d got %0d", e.acc, access_code); errors++;
				end
				if (next_pc !== e.npc) begin
					$error("next_pc exp %h got %h", e.npc, next_pc); errors++;
				end
				if (branch_taken !== e.taken) begin
					$error("branch_taken exp %b got %b", e.taken, branch_taken); errors++;
				end
				if (mispredicted !== e.mis) begin
					$error("mispredicted exp %b got %b", e.mis, mispredicted); errors++;
				end
				if (finished !== e.fin) begin
					$error("finished exp %b got %b", e.fin, finished); errors++;
				end
			end
		end
	end

	row_t directed[] = '{
		'{'{F_ADD, 32'hffffffff, 32'd1, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b1,
			'{32'd0, 32'd0, ACC_NONE, 32'd4, 1'b0, 1'b0, 1'b0}},
		'{'{F_DIV, 32'h80000000, 32'hffffffff, 32'd0, 32'd100, 1'b0, 1'b0}, 1'b1,
			'{32'h80000000, 32'd0, ACC_NONE, 32'd104, 1'b0, 1'b0, 1'b0}},
		'{'{F_REM, 32'h80000000, 32'hffffffff, 32'd0, 32'd100, 1'b0, 1'b0}, 1'b1,
			'{32'd0, 32'd0, ACC_NONE, 32'd104, 1'b0, 1'b0, 1'b0}},
		'{'{F_DIV, 32'd7, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b1,
			'{32'hffffffff, 32'd0, ACC_NONE, 32'd4, 1'b0, 1'b0, 1'b0}},
		'{'{F_DIVU, 32'd7, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b1,
			'{32'hffffffff, 32'd0, ACC_NONE, 32'd4, 1'b0, 1'b0, 1'b0}},
		'{'{F_REM, 32'd7, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b1,
			'{32'd7, 32'd0, ACC_NONE, 32'd4, 1'b0, 1'b0, 1'b0}},
		'{'{F_REMU, 32'hfffffff9, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b1,
			'{32'hfffffff9, 32'd0, ACC_NONE, 32'd4, 1'b0, 1'b0, 1'b0}},
		'{'{6'd63, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hfffffffc, 1'b1, 1'b0},
			1'b1, '{32'd0, 32'd0, ACC_NONE, 32'd0, 1'b0, 1'b0, 1'b0}},
		'{'{F_JALR, 32'd5, 32'd0, 32'd0, 32'd8, 1'b1, 1'b0}, 1'b1,
			'{32'd12, 32'd0, ACC_NONE, 32'd4, 1'b1, 1'b1, 1'b0}},
		'{'{F_LB, 32'd16, 32'd9, 32'hfffffffc, 32'd0, 1'b0, 1'b0}, 1'b1,
			'{32'd9, 32'd12, ACC_SB, 32'd4, 1'b0, 1'b0, 1'b0}},
		'{'{F_SW, 32'd16, 32'd9, 32'd4, 32'd0, 1'b0, 1'b0}, 1'b1,
			'{32'd9, 32'd20, ACC_SW, 32'd4, 1'b0, 1'b0, 1'b0}},
		'{'{F_BEQ, 32'd3, 32'd3, 32'd0, 32'd0, 1'b0, 1'b1}, 1'b1,
			'{32'd3, 32'd0, ACC_NONE, 32'd0, 1'b1, 1'b1, 1'b1}},
		'{'{F_MULH, 32'h80000000, 32'h80000000, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{F_MULHSU, 32'hffffffff, 32'hffffffff, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{F_MULHU, 32'hffffffff, 32'hffffffff, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{F_SRA, 32'h80000000, 32'd31, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{F_SRAI, 32'h80000000, 32'd0, 32'hffffffff, 32'd0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{F_JAL, 32'd0, 32'd0, 32'hfffffff0, 32'd64, 1'b0, 1'b0}, 1'b0, '0},
		'{'{F_BLT, 32'h80000000, 32'd1, 32'd8, 32'd0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{F_BGEU, 32'h80000000, 32'd1, 32'd8, 32'd0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{F_LHU, 32'hffffffff, 32'd0, 32'd1, 32'd0, 1'b0, 1'b1}, 1'b0, '0},
		'{'{F_AUIPC, 32'd0, 32'd0, 32'h12345000, 32'hfffffffc, 1'b0, 1'b0}, 1'b0, '0}
	};

	initial begin
		instr_t it;
		int k;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (k = 0; k < directed.size(); k++) begin
			if (directed[k].has_res && execute(directed[k].i) != directed[k].r) begin
				$error("table row %0d disagrees with predictor", k);
				errors++;
			end
			send_word(directed[k].i);
		end
		wait_drain();
		for (k = 0; k < N_RANDOM; k++) begin
			if (k == N_RANDOM / 3) begin
				send_idle = 70;
				recv_idle = 20;
			end else if (k == 2 * N_RANDOM / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (k == 0) begin
				send_idle = 20;
				recv_idle = 70;
			end
			if (k == 100)
				fork
					begin
						hold_recv = 1'b1;
						repeat (150) @(negedge clk);
						hold_recv = 1'b0;
					end
				join_none
			if (k == 500)
				wait_drain();
			it.op = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(45, 63))
				: 6'($urandom_range(0, 44));
			it.a = rand_word();
			it.b = ($urandom_range(0, 3) == 0) ? it.a : rand_word();
			it.imm = rand_word();
			it.pc = $urandom;
			it.pred = 1'($urandom_range(0, 1));
			it.fin = $urandom_range(0, 15) == 0;
			send_word(it);
		end
		wait_drain();
		repeat (80) @(negedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
